FILE: design/hsbm_pkg.sv
// Shared field widths, request kinds and status codes of the hashed sorted bucket map.
package hsbm_pkg;

	// Port widths of the request and result items.
	localparam int KIND_W   = 2;
	localparam int KEY_W    = 22;
	localparam int TILE_W   = 6;
	localparam int STATUS_W = 2;

	typedef logic [KIND_W-1:0]   kind_t;
	typedef logic [STATUS_W-1:0] status_t;

	// Request kinds.
	localparam kind_t KIND_INSERT = 2'd0;
	localparam kind_t KIND_REMOVE = 2'd1;
	localparam kind_t KIND_LOOKUP = 2'd2;
	localparam kind_t KIND_SET    = 2'd3;

	// Result status codes.
	localparam status_t STATUS_OK      = 2'd0;
	localparam status_t STATUS_MISSING = 2'd1;
	localparam status_t STATUS_FULL    = 2'd2;
	localparam status_t STATUS_DUP     = 2'd3;

endpackage

FILE: design/hashed_sorted_bucket_map.sv
// Top level of the hashed sorted bucket map: request sequencer, fill counts and entry memory.
//
// The map holds up to NUM_INDEXES * BUCKET_DEPTH key/tile entries in one memory, one row
// of BUCKET_DEPTH entries per bucket, each row sorted by ascending key; the bucket is the
// key modulo NUM_INDEXES and the fill count of every bucket is held in flip-flops that
// reset clears. One request is worked on at a time and gives exactly one result item.
// A lookup, a set, or a rejected insert or remove runs the hash, then s binary search
// probes of the row, then a commit step before its result appears (s is at most 5 at the
// default depth of 16). A successful insert or remove also moves m entries to keep the
// row sorted, one per cycle through the single write port of the entry memory (m is up
// to 15 at the default depth). When NUM_INDEXES is not a power of two the bucket is
// found by a multiplication with the scaled reciprocal, on a registered copy of the key.
// A new request is taken as soon as the previous result sits in the output register,
// even if it is stalled.
module hashed_sorted_bucket_map #(
	parameter int NUM_INDEXES  = 16,
	parameter int BUCKET_DEPTH = 16,
	parameter int KEY_BITS     = 22,
	parameter int TILE_BITS    = 6
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  hsbm_pkg::kind_t              kind,
	input  logic [hsbm_pkg::KEY_W-1:0]   proc_key,
	input  logic [hsbm_pkg::TILE_W-1:0]  tile_in,
	output logic                         out_valid,
	input  logic                         out_stall,
	output hsbm_pkg::status_t            status,
	output logic [hsbm_pkg::TILE_W-1:0]  tile_out
);

	import hsbm_pkg::*;

	localparam int IB      = $clog2(NUM_INDEXES);
	localparam int FW      = $clog2(BUCKET_DEPTH + 1);
	localparam int ENTRIES = NUM_INDEXES * BUCKET_DEPTH;
	localparam int AW      = $clog2(ENTRIES);
	localparam int EW      = KEY_BITS + TILE_BITS;

	// Sequencer states.
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_HASH  = 3'd1;
	localparam logic [2:0] ST_SRCH  = 3'd2;
	localparam logic [2:0] ST_HIT   = 3'd3;
	localparam logic [2:0] ST_SHIFT = 3'd4;
	localparam logic [2:0] ST_FIN   = 3'd5;
	localparam logic [2:0] ST_OUT   = 3'd6;

	logic [2:0]           state_q;
	logic                 pend_q;
	logic                 wpend_q;
	logic                 out_valid_q;
	logic [FW-1:0]        fill_q [NUM_INDEXES];

	kind_t                kind_q;
	logic [KEY_BITS-1:0]  key_q;
	logic [TILE_BITS-1:0] tile_q;
	logic [IB-1:0]        bucket_q;
	logic [AW-1:0]        base_q;
	logic [FW-1:0]        lo_q;
	logic [FW-1:0]        hi_q;
	logic [FW-1:0]        mid_q;
	logic [FW-1:0]        cur_q;
	logic [FW-1:0]        wdst_q;
	status_t              res_status_q;
	logic [TILE_BITS-1:0] res_tile_q;
	status_t              status_q;
	logic [TILE_W-1:0]    tile_out_q;

	logic                 accept_w;
	logic                 load_out_w;
	logic [KEY_BITS-1:0]  key_in_w;
	logic                 hash_done;
	logic [IB-1:0]        hash_bucket;
	logic [FW-1:0]        fill_w;
	logic [KEY_BITS-1:0]  rd_key;
	logic [TILE_BITS-1:0] rd_tile;
	logic [FW-1:0]        lo_n;
	logic [FW-1:0]        hi_n;
	logic [FW-1:0]        mid_n;
	logic                 hit_w;
	logic                 more_w;
	logic [FW-1:0]        src_w;
	logic [FW-1:0]        cur_n;
	logic                 modify_w;

	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [EW-1:0]        ram_wdata;
	logic                 ram_re;
	logic [AW-1:0]        ram_raddr;
	logic [EW-1:0]        ram_rdata;

	function automatic logic [AW-1:0] row_addr(input logic [AW-1:0] base,
	                                           input logic [FW-1:0] pos);
		return base + AW'(pos);
	endfunction

	assign accept_w = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign key_in_w = KEY_BITS'(proc_key);

	// The finished result moves into the output register once that register is free.
	assign load_out_w = (state_q == ST_OUT) && (!out_valid_q || !out_stall);

	assign fill_w  = fill_q[bucket_q];
	assign rd_key  = ram_rdata[EW-1:TILE_BITS];
	assign rd_tile = ram_rdata[TILE_BITS-1:0];

	hsbm_hash #(
		.NUM_INDEXES(NUM_INDEXES),
		.KEY_BITS(KEY_BITS)
	) u_hash (
		.clk(clk),
		.arst_n(arst_n),
		.start(accept_w),
		.key(key_in_w),
		.done(hash_done),
		.bucket(hash_bucket)
	);

	hsbm_ram #(
		.WIDTH(EW),
		.DEPTH(ENTRIES)
	) u_entries (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// One binary search step: fold in the probe that just returned, then pick the next one.
	always_comb begin
		lo_n = lo_q;
		hi_n = hi_q;
		if (pend_q) begin
			if (rd_key < key_q) begin
				lo_n = mid_q + FW'(1);
			end else begin
				hi_n = mid_q;
			end
		end
		mid_n = lo_n + ((hi_n - lo_n) >> 1);
	end

	// The lower bound holds the key itself only if it lies below the fill count.
	assign hit_w = (lo_q < fill_w) && (rd_key == key_q);

	// Entry move loop: insert walks down from the fill count, remove walks up from the hole.
	always_comb begin
		if (kind_q == KIND_INSERT) begin
			more_w = (cur_q > lo_q);
			src_w  = cur_q - FW'(1);
			cur_n  = src_w;
		end else begin
			src_w  = cur_q + FW'(1);
			more_w = (src_w < fill_w);
			cur_n  = src_w;
		end
	end

	assign modify_w = (res_status_q == STATUS_OK);

	// Entry memory port control.
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = row_addr(base_q, mid_n);
		ram_we    = 1'b0;
		ram_waddr = row_addr(base_q, lo_q);
		ram_wdata = {key_q, tile_q};
		unique case (state_q)
			ST_SRCH: begin
				if (lo_n < hi_n) begin
					ram_re = 1'b1;
				end else begin
					ram_re    = (lo_n < fill_w);
					ram_raddr = row_addr(base_q, lo_n);
				end
			end
			ST_SHIFT: begin
				ram_re    = more_w;
				ram_raddr = row_addr(base_q, src_w);
				ram_we    = wpend_q;
				ram_waddr = row_addr(base_q, wdst_q);
				ram_wdata = ram_rdata;
			end
			ST_FIN: begin
				ram_we = modify_w && (kind_q == KIND_INSERT || kind_q == KIND_SET);
			end
			default: begin
			end
		endcase
	end

	// Sequencer, probe flags, fill counts and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pend_q      <= 1'b0;
			wpend_q     <= 1'b0;
			out_valid_q <= 1'b0;
			for (int b = 0; b < NUM_INDEXES; b++) begin
				fill_q[b] <= '0;
			end
		end else begin
			if (load_out_w) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept_w) begin
						state_q <= ST_HASH;
					end
				end
				ST_HASH: begin
					if (hash_done) begin
						pend_q  <= 1'b0;
						state_q <= ST_SRCH;
					end
				end
				ST_SRCH: begin
					pend_q <= (lo_n < hi_n);
					if (!(lo_n < hi_n)) begin
						state_q <= ST_HIT;
					end
				end
				ST_HIT: begin
					wpend_q <= 1'b0;
					if (hit_w && kind_q == KIND_REMOVE) begin
						state_q <= ST_SHIFT;
					end else if (!hit_w && kind_q == KIND_INSERT &&
					             fill_w < FW'(BUCKET_DEPTH)) begin
						state_q <= ST_SHIFT;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_SHIFT: begin
					// The last pending move is written in the cycle that leaves.
					wpend_q <= more_w;
					if (!more_w) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (modify_w && kind_q == KIND_INSERT) begin
						fill_q[bucket_q] <= fill_w + FW'(1);
					end else if (modify_w && kind_q == KIND_REMOVE) begin
						fill_q[bucket_q] <= fill_w - FW'(1);
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (load_out_w) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request fields, search bounds, move pointers and the result.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept_w) begin
					kind_q <= kind;
					key_q  <= key_in_w;
					tile_q <= TILE_BITS'(tile_in);
				end
			end
			ST_HASH: begin
				if (hash_done) begin
					bucket_q <= hash_bucket;
					base_q   <= AW'(hash_bucket) * AW'(BUCKET_DEPTH);
					lo_q     <= '0;
					hi_q     <= fill_q[hash_bucket];
				end
			end
			ST_SRCH: begin
				lo_q  <= lo_n;
				hi_q  <= hi_n;
				mid_q <= mid_n;
			end
			ST_HIT: begin
				res_tile_q <= '0;
				if (kind_q == KIND_INSERT) begin
					cur_q <= fill_w;
					if (hit_w) begin
						res_status_q <= STATUS_DUP;
					end else if (fill_w >= FW'(BUCKET_DEPTH)) begin
						res_status_q <= STATUS_FULL;
					end else begin
						res_status_q <= STATUS_OK;
					end
				end else begin
					cur_q <= lo_q;
					if (!hit_w) begin
						res_status_q <= STATUS_MISSING;
					end else begin
						res_status_q <= STATUS_OK;
						if (kind_q == KIND_LOOKUP) begin
							res_tile_q <= rd_tile;
						end
					end
				end
			end
			ST_SHIFT: begin
				if (more_w) begin
					cur_q  <= cur_n;
					wdst_q <= cur_q;
				end
			end
			ST_OUT: begin
				if (load_out_w) begin
					status_q   <= res_status_q;
					tile_out_q <= TILE_W'(res_tile_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign tile_out  = tile_out_q;

	// The entry memory is written only while moving entries or committing a request.
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_SHIFT || state_q == ST_FIN))
		else $error("entry memory written outside a move or commit");

	// The binary search window never turns inside out.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SRCH) |-> (lo_q <= hi_q && hi_q <= fill_w))
		else $error("search bounds out of order");

	// No bucket ever holds more entries than a row has room for.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE && state_q != ST_HASH) |-> (fill_w <= FW'(BUCKET_DEPTH)))
		else $error("bucket fill count beyond depth");

	// The bucket unit reports only for the request being hashed.
	assert property (@(posedge clk) disable iff (!arst_n)
		hash_done |-> (state_q == ST_HASH))
		else $error("bucket result outside the hash phase");

	// A result item appears only when the sequencer hands one over.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_OUT))
		else $error("result item raised without a finished request");

endmodule

FILE: design/hsbm_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module hsbm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: design/hsbm_hash.sv
// Bucket selection unit: reduces a key modulo the number of buckets.
module hsbm_hash #(
	parameter int NUM_INDEXES = 16,
	parameter int KEY_BITS    = 22,
	localparam int IB = $clog2(NUM_INDEXES)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [KEY_BITS-1:0] key,
	output logic                done,
	output logic [IB-1:0]       bucket
);

	localparam bit IS_POW2 = ((NUM_INDEXES & (NUM_INDEXES - 1)) == 0);

	generate
		if (IS_POW2) begin : g_mask
			logic          done_q;
			logic [IB-1:0] bucket_q;

			// The remainder by a power of two is the low key bits.
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done_q <= 1'b0;
				end else begin
					done_q <= start;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					bucket_q <= key[IB-1:0];
				end
			end

			assign done   = done_q;
			assign bucket = bucket_q;
		end else begin : g_recip
			// The quotient comes from a multiplication by the reciprocal scaled by
			// 2^(KEY_BITS+IB) and rounded up, which is exact for every key of KEY_BITS bits.
			localparam int SH = KEY_BITS + IB;
			localparam int MW = KEY_BITS + 1;
			localparam int PW = KEY_BITS + MW;
			localparam int QW = PW - SH;
			localparam logic [MW-1:0] RECIP =
				MW'(((64'd1 << SH) + 64'(NUM_INDEXES) - 64'd1) / 64'(NUM_INDEXES));

			logic                valid_s1;
			logic                done_s2;
			logic [KEY_BITS-1:0] key_s1;
			logic [IB-1:0]       bucket_s2;
			logic [PW-1:0]       prod;
			logic [QW-1:0]       quot;
			logic [KEY_BITS-1:0] rem;

			// Quotient and remainder of the registered key.
			assign prod = PW'(key_s1) * PW'(RECIP);
			assign quot = prod[PW-1:SH];
			assign rem  = key_s1 - KEY_BITS'(quot) * KEY_BITS'(NUM_INDEXES);

			// Two stage valid chain.
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_s1 <= 1'b0;
					done_s2  <= 1'b0;
				end else begin
					valid_s1 <= start;
					done_s2  <= valid_s1;
				end
			end

			// Key capture, then the remainder.
			always_ff @(posedge clk) begin
				if (start) begin
					key_s1 <= key;
				end
				if (valid_s1) begin
					bucket_s2 <= rem[IB-1:0];
				end
			end

			assign done   = done_s2;
			assign bucket = bucket_s2;
		end
	endgenerate

endmodule
